// File: design/rpla_pkg.sv
// ----------------------------------------------------------------------------
// rpla_pkg
// Shared types and constants for the rectilinear polygon lattice area block.
// ----------------------------------------------------------------------------
package rpla_pkg;

  // Default widths of the walk state and of the step length.
  localparam int COORD_BITS_DEF  = 32;
  localparam int LENGTH_BITS_DEF = 20;

  // Fixed field widths of the ports.
  localparam int FIELD_LEN_BITS = 20;
  localparam int HEX_BITS       = 24;
  localparam int NIB_BITS       = 4;

  // Fixed widths of the accumulators and of the result.
  localparam int PERIM_BITS = 32;
  localparam int SUM_BITS   = 64;
  localparam int CELLS_BITS = 62;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  // Sticky per-path error flags.
  typedef struct packed {
    logic bad;
    logic ovf;
  } err_t;

  // Occupancy of one pipeline register.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_t;

endpackage

// File: design/rectilinear_polygon_lattice_area.sv
// ----------------------------------------------------------------------------
// rectilinear_polygon_lattice_area
// Walks a closed rectilinear path step by step and reports the covered cells.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+----------------------------------
//   in       | input     | in_valid_i / in_stall_o   | dir_i, distance_i, hex_word_i,
//            |           |                           | last_i
//   out      | output    | out_valid_o / out_stall_i | lagoon_cells_o, not_closed_o,
//            |           |                           | bad_direction_o, overflow_o
//   cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (hex_mode)
//
// One step is taken every cycle while the input is not stalled. A step passes
// an input register, the walk stage (vertex move, perimeter and one |y| * length
// multiply), the sum stage (one 64-bit signed accumulate) and the result stage
// (one 64-bit add with saturation). Reset clears the vertex, sums, error flags,
// hex_mode and every valid bit. A stall on the output only holds back a stage
// whose item carries a result; steps that are not last drain past a stalled
// result, so the input stalls only once the pipeline is full behind it. The
// config port is always ready.
//
// The shoelace sum adds y * dx on horizontal steps; the covered cell count is
// |sum| + perimeter/2 + 1 by Pick's theorem. Each stage keeps its own part of
// the path state and clears it when the last step of a path passes, so the next
// path can follow right behind.
// ----------------------------------------------------------------------------
module rectilinear_polygon_lattice_area import rpla_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_data_i,
  // Step input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                dir_i,
  input  logic [FIELD_LEN_BITS-1:0] distance_i,
  input  logic [HEX_BITS-1:0]       hex_word_i,
  input  logic                      last_i,
  // Result output channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [CELLS_BITS-1:0]     lagoon_cells_o,
  output logic                      not_closed_o,
  output logic                      bad_direction_o,
  output logic                      overflow_o
);

  // Only the low LENGTH_BITS of a step length count, and a field has 20 bits.
  localparam int LenW = (LENGTH_BITS < FIELD_LEN_BITS) ? LENGTH_BITS : FIELD_LEN_BITS;

  logic hex_mode_q;

  stage_t               st0, st1, st2;
  dir_e                 dec_dir;
  logic [LenW-1:0]      dec_len;
  logic                 dec_bad;

  logic [SUM_BITS-1:0]   walk_mag;
  logic                  walk_tneg, walk_not_closed;
  logic [PERIM_BITS-1:0] walk_perim;
  err_t                  walk_err;

  logic [SUM_BITS-1:0]   acc_sum;
  logic [PERIM_BITS-1:0] acc_perim;
  logic                  acc_not_closed;
  err_t                  acc_err;

  logic out_free, load_out, accept;
  logic leave0, leave1, leave2;
  logic ready0, ready1, ready2;

  // Configuration register: a transfer lands whenever valid is high.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hex_mode_q <= cfg_data_i;
    end
  end

  // Pipeline flow. The output register is free when empty or being taken.
  // The sum stage with a step that is not last never waits for the output.
  assign out_free = !out_valid_o || !out_stall_i;
  assign load_out = st2.valid && st2.last && out_free;
  assign leave2   = st2.valid && (!st2.last || out_free);
  assign ready2   = !st2.valid || leave2;
  assign leave1   = st1.valid && ready2;
  assign ready1   = !st1.valid || leave1;
  assign leave0   = st0.valid && ready1;
  assign ready0   = !st0.valid || leave0;

  assign in_stall_o = !ready0;
  assign accept     = in_valid_i && ready0;

  rpla_decode #(
    .LEN_BITS (LenW)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hex_mode_i (hex_mode_q),
    .load_i     (accept),
    .leave_i    (leave0),
    .dir_i      (dir_i),
    .distance_i (distance_i),
    .hex_word_i (hex_word_i),
    .last_i     (last_i),
    .st_o       (st0),
    .dir_o      (dec_dir),
    .len_o      (dec_len),
    .bad_o      (dec_bad)
  );

  rpla_walk #(
    .COORD_BITS (COORD_BITS),
    .LEN_BITS   (LenW)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (leave0),
    .leave_i      (leave1),
    .st_i         (st0),
    .dir_i        (dec_dir),
    .len_i        (dec_len),
    .bad_i        (dec_bad),
    .st_o         (st1),
    .mag_o        (walk_mag),
    .tneg_o       (walk_tneg),
    .perim_o      (walk_perim),
    .not_closed_o (walk_not_closed),
    .err_o        (walk_err)
  );

  rpla_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (leave1),
    .leave_i      (leave2),
    .st_i         (st1),
    .mag_i        (walk_mag),
    .tneg_i       (walk_tneg),
    .perim_i      (walk_perim),
    .not_closed_i (walk_not_closed),
    .err_i        (walk_err),
    .st_o         (st2),
    .sum_o        (acc_sum),
    .perim_o      (acc_perim),
    .not_closed_o (acc_not_closed),
    .err_o        (acc_err)
  );

  rpla_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load_out),
    .stall_i      (out_stall_i),
    .sum_i        (acc_sum),
    .perim_i      (acc_perim),
    .not_closed_i (acc_not_closed),
    .err_i        (acc_err),
    .valid_o      (out_valid_o),
    .cells_o      (lagoon_cells_o),
    .not_closed_o (not_closed_o),
    .bad_o        (bad_direction_o),
    .ovf_o        (overflow_o)
  );

`ifndef SYNTH
  // With nothing in flight the input must never be stalled.
  a_empty_not_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!st0.valid && !st1.valid && !st2.valid) |-> !in_stall_o)
    else $error("input stalled while the pipeline is empty");

  // A new result only appears after a last step left the sum stage.
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st2.valid && st2.last))
    else $error("result appeared without a last step");

  // An accepted step always lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> st0.valid)
    else $error("accepted step was lost");
`endif

endmodule

// File: design/rpla_decode.sv
// ----------------------------------------------------------------------------
// rpla_decode
// Input register: decodes one step into direction, length and a bad flag.
// ----------------------------------------------------------------------------
module rpla_decode import rpla_pkg::*; #(
  parameter int LEN_BITS = LENGTH_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      hex_mode_i,
  input  logic                      load_i,
  input  logic                      leave_i,
  input  logic [1:0]                dir_i,
  input  logic [FIELD_LEN_BITS-1:0] distance_i,
  input  logic [HEX_BITS-1:0]       hex_word_i,
  input  logic                      last_i,
  output stage_t                    st_o,
  output dir_e                      dir_o,
  output logic [LEN_BITS-1:0]       len_o,
  output logic                      bad_o
);

  logic                valid_q;
  logic                last_q;
  dir_e                dir_d, dir_q;
  logic [LEN_BITS-1:0] len_d, len_q;
  logic                bad_d, bad_q;
  logic [NIB_BITS-1:0] nib;

  assign nib = hex_word_i[NIB_BITS-1:0];

  always_comb begin
    dir_d = dir_e'(dir_i);
    len_d = distance_i[LEN_BITS-1:0];
    bad_d = 1'b0;
    if (hex_mode_i) begin
      if (nib[NIB_BITS-1:2] != '0) begin
        // Direction code out of range: the step counts as zero length.
        dir_d = DIR_RIGHT;
        len_d = '0;
        bad_d = 1'b1;
      end else begin
        dir_d = dir_e'(nib[1:0]);
        len_d = hex_word_i[NIB_BITS +: LEN_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (leave_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dir_q  <= dir_d;
      len_q  <= len_d;
      bad_q  <= bad_d;
      last_q <= last_i;
    end
  end

  assign st_o  = '{valid: valid_q, last: last_q};
  assign dir_o = dir_q;
  assign len_o = len_q;
  assign bad_o = bad_q;

endmodule

// File: design/rpla_walk.sv
// ----------------------------------------------------------------------------
// rpla_walk
// Moves the current vertex, adds to the perimeter and forms |y| * length.
// ----------------------------------------------------------------------------
module rpla_walk import rpla_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LEN_BITS   = LENGTH_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  leave_i,
  input  stage_t                st_i,
  input  dir_e                  dir_i,
  input  logic [LEN_BITS-1:0]   len_i,
  input  logic                  bad_i,
  output stage_t                st_o,
  output logic [SUM_BITS-1:0]   mag_o,
  output logic                  tneg_o,
  output logic [PERIM_BITS-1:0] perim_o,
  output logic                  not_closed_o,
  output err_t                  err_o
);

  localparam int ProdBits = COORD_BITS + LEN_BITS;
  localparam int WideBits = (ProdBits > SUM_BITS) ? ProdBits : SUM_BITS;
  localparam int MoveBits = ((COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS) + 2;

  logic [COORD_BITS-1:0] x_q, y_q, x_n, y_n, cur, moved;
  logic [PERIM_BITS-1:0] perim_q;
  err_t                  err_q, err_n;
  logic                  valid_q, last_q;

  logic                  horiz, neg, coord_ovf, mul_ovf, perim_ovf, tneg;
  logic [COORD_BITS-1:0] ymag;
  logic [ProdBits-1:0]   prod;
  logic [WideBits-1:0]   prod_w;
  logic [MoveBits-1:0]   cur_ext, len_ext, sum_ext;
  logic [PERIM_BITS:0]   perim_sum;

  logic [SUM_BITS-1:0]   mag_q;
  logic                  tneg_q, closed_n, not_closed_q;
  logic [PERIM_BITS-1:0] perim_out_q;
  err_t                  err_out_q;

  assign horiz = (dir_i == DIR_RIGHT) || (dir_i == DIR_LEFT);
  assign neg   = (dir_i == DIR_LEFT) || (dir_i == DIR_UP);

  // Shoelace term magnitude, taken with y before the step.
  assign ymag    = y_q[COORD_BITS-1] ? (~y_q + 1'b1) : y_q;
  assign prod    = ProdBits'(ymag) * ProdBits'(len_i);
  assign prod_w  = WideBits'(prod);
  assign mul_ovf = horiz && (|prod_w[WideBits-1:SUM_BITS-1]);
  assign tneg    = (dir_i == DIR_LEFT) ? !y_q[COORD_BITS-1] : y_q[COORD_BITS-1];

  // Coordinate move in a wider word; out of range when the top bits disagree.
  assign cur       = horiz ? x_q : y_q;
  assign cur_ext   = {{(MoveBits-COORD_BITS){cur[COORD_BITS-1]}}, cur};
  assign len_ext   = MoveBits'(len_i);
  assign sum_ext   = neg ? (cur_ext - len_ext) : (cur_ext + len_ext);
  assign coord_ovf = !((&sum_ext[MoveBits-1:COORD_BITS-1]) ||
                       (~|sum_ext[MoveBits-1:COORD_BITS-1]));
  assign moved     = sum_ext[COORD_BITS-1:0];
  assign x_n       = horiz ? moved : x_q;
  assign y_n       = horiz ? y_q : moved;
  assign closed_n  = (x_n == '0) && (y_n == '0);

  assign perim_sum = {1'b0, perim_q} + (PERIM_BITS+1)'(len_i);
  assign perim_ovf = perim_sum[PERIM_BITS];

  assign err_n.bad = err_q.bad | bad_i;
  assign err_n.ovf = err_q.ovf | coord_ovf | perim_ovf | mul_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      perim_q <= '0;
      err_q   <= '0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (leave_i) begin
        valid_q <= 1'b0;
      end
      if (load_i) begin
        if (st_i.last) begin
          x_q     <= '0;
          y_q     <= '0;
          perim_q <= '0;
          err_q   <= '0;
        end else begin
          x_q     <= x_n;
          y_q     <= y_n;
          perim_q <= perim_sum[PERIM_BITS-1:0];
          err_q   <= err_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      last_q       <= st_i.last;
      mag_q        <= horiz ? prod_w[SUM_BITS-1:0] : '0;
      tneg_q       <= horiz && tneg;
      perim_out_q  <= perim_sum[PERIM_BITS-1:0];
      not_closed_q <= !closed_n;
      err_out_q    <= err_n;
    end
  end

  assign st_o         = '{valid: valid_q, last: last_q};
  assign mag_o        = mag_q;
  assign tneg_o       = tneg_q;
  assign perim_o      = perim_out_q;
  assign not_closed_o = not_closed_q;
  assign err_o        = err_out_q;

endmodule

// File: design/rpla_accum.sv
// ----------------------------------------------------------------------------
// rpla_accum
// Accumulates the signed shoelace sum and checks it for signed overflow.
// ----------------------------------------------------------------------------
module rpla_accum import rpla_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  leave_i,
  input  stage_t                st_i,
  input  logic [SUM_BITS-1:0]   mag_i,
  input  logic                  tneg_i,
  input  logic [PERIM_BITS-1:0] perim_i,
  input  logic                  not_closed_i,
  input  err_t                  err_i,
  output stage_t                st_o,
  output logic [SUM_BITS-1:0]   sum_o,
  output logic [PERIM_BITS-1:0] perim_o,
  output logic                  not_closed_o,
  output err_t                  err_o
);

  logic [SUM_BITS-1:0]   sum_q, term, sum_n, sum_out_q;
  logic                  ovf_q, add_ovf;
  logic                  valid_q, last_q, not_closed_q;
  logic [PERIM_BITS-1:0] perim_q;
  err_t                  err_n, err_out_q;

  assign term    = tneg_i ? (~mag_i + 1'b1) : mag_i;
  assign sum_n   = sum_q + term;
  assign add_ovf = (sum_q[SUM_BITS-1] == term[SUM_BITS-1]) &&
                   (sum_n[SUM_BITS-1] != sum_q[SUM_BITS-1]);

  assign err_n.bad = err_i.bad;
  assign err_n.ovf = err_i.ovf | ovf_q | add_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (leave_i) begin
        valid_q <= 1'b0;
      end
      if (load_i) begin
        if (st_i.last) begin
          sum_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          sum_q <= sum_n;
          ovf_q <= ovf_q | add_ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      last_q       <= st_i.last;
      sum_out_q    <= sum_n;
      perim_q      <= perim_i;
      not_closed_q <= not_closed_i;
      err_out_q    <= err_n;
    end
  end

  assign st_o         = '{valid: valid_q, last: last_q};
  assign sum_o        = sum_out_q;
  assign perim_o      = perim_q;
  assign not_closed_o = not_closed_q;
  assign err_o        = err_out_q;

endmodule

// File: design/rpla_result.sv
// ----------------------------------------------------------------------------
// rpla_result
// Forms |sum| + perimeter/2 + 1 with saturation and holds the result.
// ----------------------------------------------------------------------------
module rpla_result import rpla_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  stall_i,
  input  logic [SUM_BITS-1:0]   sum_i,
  input  logic [PERIM_BITS-1:0] perim_i,
  input  logic                  not_closed_i,
  input  err_t                  err_i,
  output logic                  valid_o,
  output logic [CELLS_BITS-1:0] cells_o,
  output logic                  not_closed_o,
  output logic                  bad_o,
  output logic                  ovf_o
);

  logic                  valid_q, neg, sat;
  logic [SUM_BITS-1:0]   base;
  logic [PERIM_BITS:0]   addend;
  logic [SUM_BITS:0]     total;
  logic [CELLS_BITS-1:0] cells_q;
  logic                  not_closed_q, bad_q, ovf_q;

  // For a negative sum, -sum + k equals ~sum + (k + 1): one adder covers both signs.
  assign neg    = sum_i[SUM_BITS-1];
  assign base   = neg ? ~sum_i : sum_i;
  assign addend = (PERIM_BITS+1)'(perim_i[PERIM_BITS-1:1]) +
                  (neg ? (PERIM_BITS+1)'(2) : (PERIM_BITS+1)'(1));
  assign total  = {1'b0, base} + (SUM_BITS+1)'(addend);
  assign sat    = |total[SUM_BITS:CELLS_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cells_q      <= sat ? '1 : total[CELLS_BITS-1:0];
      not_closed_q <= not_closed_i;
      bad_q        <= err_i.bad;
      ovf_q        <= err_i.ovf | sat;
    end
  end

  assign valid_o      = valid_q;
  assign cells_o      = cells_q;
  assign not_closed_o = not_closed_q;
  assign bad_o        = bad_q;
  assign ovf_o        = ovf_q;

endmodule

// File: bench/tb_rectilinear_polygon_lattice_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectilinear_polygon_lattice_area
// Self-checking bench for the rectilinear polygon lattice area block.
//
// Steps are driven through the valid/stall input channel in both length
// modes. A scoreboard walks the same path, predicts the covered cell count
// and the three flags for every last step, and compares each result
// transfer against the oldest prediction. Both sides idle at random, and
// one long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------

import rpla_pkg::*;

class lattice_area_scoreboard;

  localparam int CW = COORD_BITS_DEF;
  localparam longint unsigned LEN_MASK  = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
  localparam longint unsigned CELLS_MAX = (64'd1 << CELLS_BITS) - 64'd1;
  localparam longint unsigned SUM_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [CELLS_BITS-1:0] cells;
    logic                  not_closed;
    logic                  bad_direction;
    logic                  overflow;
  } cell_count_t;

  bit                    hex_mode;
  logic signed [CW-1:0]  pos_x;
  logic signed [CW-1:0]  pos_y;
  logic [SUM_BITS-1:0]   area_sum;
  logic [PERIM_BITS-1:0] perim;
  err_t                  err;
  cell_count_t           expected_q[$];

  int mismatches;
  int steps_seen;
  int results_seen;
  int unclosed_seen;
  int bad_seen;
  int ovf_seen;

  function new();
    hex_mode      = 1'b0;
    mismatches    = 0;
    steps_seen    = 0;
    results_seen  = 0;
    unclosed_seen = 0;
    bad_seen      = 0;
    ovf_seen      = 0;
    clear_walk();
  endfunction

  function void clear_walk();
    pos_x    = '0;
    pos_y    = '0;
    area_sum = '0;
    perim    = '0;
    err      = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Moves one coordinate; a result outside the signed range wraps and is flagged.
  function logic signed [CW-1:0] step_coord(logic signed [CW-1:0] c, longint unsigned len,
                                            bit toward_neg);
    longint lim_hi;
    longint lim_lo;
    longint n;
    lim_hi = (longint'(1) << (CW - 1)) - 1;
    lim_lo = -lim_hi - 1;
    n = toward_neg ? longint'(c) - longint'(len) : longint'(c) + longint'(len);
    if (n < lim_lo || n > lim_hi) err.ovf = 1'b1;
    return n[CW-1:0];
  endfunction

  // Takes one accepted step and, on a last step, queues the expected result.
  function void note_step(logic [1:0] dir, logic [FIELD_LEN_BITS-1:0] distance,
                          logic [HEX_BITS-1:0] hex_word, logic last);
    dir_e                  d;
    logic [NIB_BITS-1:0]   nib;
    longint unsigned       len;
    longint                yv;
    longint unsigned       ymag;
    longint unsigned       mag;
    longint unsigned       term;
    longint unsigned       s;
    longint unsigned       amag;
    longint unsigned       total;
    logic [PERIM_BITS:0]   p;
    bit                    y_neg;
    bit                    t_neg;
    cell_count_t           exp_r;
    steps_seen++;
    if (hex_mode) begin
      nib = hex_word[NIB_BITS-1:0];
      len = 64'(hex_word[HEX_BITS-1:NIB_BITS]) & LEN_MASK;
      if (nib > NIB_BITS'(DIR_UP)) begin
        // A direction code beyond up counts as a zero-length step.
        err.bad = 1'b1;
        len     = 0;
        d       = DIR_RIGHT;
      end else begin
        d = dir_e'(nib[1:0]);
      end
    end else begin
      d   = dir_e'(dir);
      len = 64'(distance) & LEN_MASK;
    end

    p = {1'b0, perim} + (PERIM_BITS + 1)'(len);
    if (p[PERIM_BITS]) err.ovf = 1'b1;
    perim = p[PERIM_BITS-1:0];

    if (d == DIR_RIGHT || d == DIR_LEFT) begin
      yv    = pos_y;
      y_neg = pos_y[CW-1];
      ymag  = y_neg ? -yv : yv;
      t_neg = (d == DIR_LEFT) ? !y_neg : y_neg;
      mag   = ymag * len;
      if (len != 0 && ymag > SUM_POS_MAX / len) err.ovf = 1'b1;
      term = t_neg ? (~mag + 64'd1) : mag;
      s    = area_sum + term;
      if (area_sum[63] == term[63] && s[63] != area_sum[63]) err.ovf = 1'b1;
      area_sum = s;
      pos_x    = step_coord(pos_x, len, d == DIR_LEFT);
    end else begin
      pos_y = step_coord(pos_y, len, d == DIR_UP);
    end

    if (!last) return;

    amag  = area_sum[63] ? (~area_sum + 64'd1) : area_sum;
    total = amag + 64'(perim >> 1) + 64'd1;
    exp_r.bad_direction = err.bad;
    exp_r.overflow      = err.ovf;
    if (total > CELLS_MAX) begin
      total          = CELLS_MAX;
      exp_r.overflow = 1'b1;
    end
    exp_r.cells      = total[CELLS_BITS-1:0];
    exp_r.not_closed = (pos_x != 0) || (pos_y != 0);
    if (exp_r.not_closed)    unclosed_seen++;
    if (exp_r.bad_direction) bad_seen++;
    if (exp_r.overflow)      ovf_seen++;
    expected_q.insert(expected_q.size(), exp_r);
    clear_walk();
  endfunction

  task report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  task check_result(logic [CELLS_BITS-1:0] cells, logic not_closed, logic bad_direction,
                    logic overflow);
    cell_count_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no path pending, lagoon_cells", 64'(cells), 0);
      return;
    end
    e = expected_q[0];
    expected_q.delete(0);
    if (cells !== e.cells) report_mismatch("lagoon_cells", 64'(cells), 64'(e.cells));
    if (not_closed !== e.not_closed)
      report_mismatch("not_closed", 64'(not_closed), 64'(e.not_closed));
    if (bad_direction !== e.bad_direction)
      report_mismatch("bad_direction", 64'(bad_direction), 64'(e.bad_direction));
    if (overflow !== e.overflow)
      report_mismatch("overflow", 64'(overflow), 64'(e.overflow));
  endtask

  task check_drained();
    if (expected_q.size() != 0)
      report_mismatch("results still missing at end, count", 64'(expected_q.size()), 0);
  endtask

endclass

module tb_rectilinear_polygon_lattice_area;

  // Length of the one long output hold-off, and how many single-step paths
  // are offered while it lasts.
  localparam int     HOLD_CYCLES    = 300;
  localparam int     PRESSURE_PATHS = 40;
  // Quiet cycles after the last expected result; the pipeline is four deep.
  localparam int     DRAIN_CYCLES   = 16;
  // Long open walk: full-length steps down, then full-length steps right,
  // for large coordinates, a large perimeter and a large shoelace sum.
  localparam int     WALK_DOWN      = 40;
  localparam int     WALK_RIGHT     = 40;
  localparam longint LIMIT_NS       = 4_000_000;

  localparam logic [FIELD_LEN_BITS-1:0] LEN_MAX     = '1;
  localparam logic [NIB_BITS-1:0]       NIB_BAD_MIN = 4'h4;
  localparam logic [NIB_BITS-1:0]       NIB_BAD_MAX = 4'hF;

  // One planned step of a generated path.
  typedef struct packed {
    dir_e                      d;
    logic [FIELD_LEN_BITS-1:0] len;
    logic                      bad;
  } step_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_data_i  = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic [1:0]                dir_i       = '0;
  logic [FIELD_LEN_BITS-1:0] distance_i  = '0;
  logic [HEX_BITS-1:0]       hex_word_i  = '0;
  logic                      last_i      = 1'b0;
  logic                      out_stall_i = 1'b0;

  logic                  cfg_ready_o;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [CELLS_BITS-1:0] lagoon_cells_o;
  logic                  not_closed_o;
  logic                  bad_direction_o;
  logic                  overflow_o;

  rectilinear_polygon_lattice_area #(
    .COORD_BITS (COORD_BITS_DEF),
    .LENGTH_BITS(LENGTH_BITS_DEF)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dir_i          (dir_i),
    .distance_i     (distance_i),
    .hex_word_i     (hex_word_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lagoon_cells_o (lagoon_cells_o),
    .not_closed_o   (not_closed_o),
    .bad_direction_o(bad_direction_o),
    .overflow_o     (overflow_o)
  );

  lattice_area_scoreboard sb;

  // Knobs that the stimulus sequence turns on and off per phase.
  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  bit hold_req = 1'b0;

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Every result transfer is compared at the rising edge that completes it.
  // Inputs only move at falling edges, so the sampled values are settled.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(lagoon_cells_o, not_closed_o, bad_direction_o, overflow_o);
  end

  // Output side. Random stall bursts while enabled, and on request one long
  // hold-off counted here, so the sender keeps offering steps until the
  // pipeline is full and the input stalls.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // The run ends here if the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one step and waits for its transfer. A random gap may come first.
  // The payload is held for as long as the block stalls.
  task automatic send_step(logic [1:0] d, logic [FIELD_LEN_BITS-1:0] step_dist,
                           logic [HEX_BITS-1:0] hw, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    dir_i      <= d;
    distance_i <= step_dist;
    hex_word_i <= hw;
    last_i     <= last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_step(dir_i, distance_i, hex_word_i, last_i);
  endtask

  // Encodes a planned step for the current mode. The unused fields carry noise.
  task automatic send_move(step_t mv, logic last);
    logic [NIB_BITS-1:0] nib;
    if (sb.hex_mode) begin
      nib = mv.bad ? NIB_BITS'($urandom_range(NIB_BAD_MIN, NIB_BAD_MAX))
                   : NIB_BITS'(mv.d);
      send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {mv.len, nib}, last);
    end else begin
      send_step(mv.d, mv.len, HEX_BITS'($urandom), last);
    end
  endtask

  // Writes hex_mode through the config channel; the block must be idle.
  task automatic write_mode(bit m);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.hex_mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering steps, waits for every pending result and then lets the
  // pipeline run empty, since steps without last leave nothing to wait for.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly short steps so that paths stay small, with some full-width ones.
  function automatic logic [FIELD_LEN_BITS-1:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return FIELD_LEN_BITS'($urandom_range(0, 15));
    if (r < 9) return FIELD_LEN_BITS'($urandom_range(0, 4095));
    if ($urandom_range(0, 1) == 0) return LEN_MAX;
    return FIELD_LEN_BITS'($urandom);
  endfunction

  // A random walk closed by return legs, so the path ends at the origin.
  // In hex mode some steps carry a bad direction code; their length is
  // ignored and the path stays closed. A broken path loses one step.
  task automatic send_path(int n_moves, bit broken);
    step_t  path[$];
    step_t  mv;
    longint dx;
    longint dy;
    longint step_len;
    longint left_len;
    dx = 0;
    dy = 0;
    repeat (n_moves) begin
      mv.d   = dir_e'($urandom_range(0, 3));
      mv.len = pick_len();
      mv.bad = sb.hex_mode && ($urandom_range(0, 19) == 0);
      step_len = mv.len;
      if (!mv.bad) begin
        case (mv.d)
          DIR_RIGHT: dx = dx + step_len;
          DIR_LEFT:  dx = dx - step_len;
          DIR_DOWN:  dy = dy + step_len;
          default:   dy = dy - step_len;
        endcase
      end
      path.insert(path.size(), mv);
    end
    mv.bad = 1'b0;
    while (dx != 0) begin
      left_len = (dx > 0) ? dx : -dx;
      mv.len   = (left_len > longint'(LEN_MAX)) ? LEN_MAX : left_len[FIELD_LEN_BITS-1:0];
      mv.d     = (dx > 0) ? DIR_LEFT : DIR_RIGHT;
      step_len = mv.len;
      dx       = (dx > 0) ? dx - step_len : dx + step_len;
      path.insert(path.size(), mv);
    end
    while (dy != 0) begin
      left_len = (dy > 0) ? dy : -dy;
      mv.len   = (left_len > longint'(LEN_MAX)) ? LEN_MAX : left_len[FIELD_LEN_BITS-1:0];
      mv.d     = (dy > 0) ? DIR_UP : DIR_DOWN;
      step_len = mv.len;
      dy       = (dy > 0) ? dy - step_len : dy + step_len;
      path.insert(path.size(), mv);
    end
    if (broken && path.size() > 1) path.delete($urandom_range(0, path.size() - 1));
    foreach (path[i]) send_move(path[i], i == path.size() - 1);
  endtask

  // Unshaped steps: any field value, last now and then.
  task automatic send_noise();
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), HEX_BITS'($urandom),
              $urandom_range(0, 3) == 0);
  endtask

  task automatic random_phase(int n_items);
    int start;
    int r;
    start = sb.steps_seen;
    while (sb.steps_seen - start < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 7)       send_path($urandom_range(1, 8), 1'b0);
      else if (r == 7) send_path($urandom_range(2, 8), 1'b1);
      else             repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  initial begin
    step_t mv;
    sb = new();

    // Reset is held low at the start and released at a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed steps with dir and distance.
    write_mode(1'b0);
    // A 5 by 5 square walked clockwise: every direction once.
    send_step(DIR_RIGHT, 20'd5, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_DOWN,  20'd5, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_LEFT,  20'd5, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_UP,    20'd5, HEX_BITS'($urandom), 1'b1);
    // A path of one zero-length step covers a single cell.
    send_step(DIR_RIGHT, 20'd0, HEX_BITS'($urandom), 1'b1);
    // Out and back at full length: no area, only the perimeter counts.
    send_step(DIR_DOWN,  LEN_MAX, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_UP,    LEN_MAX, HEX_BITS'($urandom), 1'b1);
    // A rectangle above the x axis, so the shoelace sum comes out negative.
    send_step(DIR_UP,    20'd7, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_RIGHT, 20'd9, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_DOWN,  20'd7, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_LEFT,  20'd9, HEX_BITS'($urandom), 1'b1);
    // A path that does not return to the origin.
    send_step(DIR_RIGHT, 20'd3, HEX_BITS'($urandom), 1'b0);
    send_step(DIR_DOWN,  20'd4, HEX_BITS'($urandom), 1'b1);
    wait_idle();

    // Directed steps from the hex word.
    write_mode(1'b1);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {20'd16, 2'b00, DIR_RIGHT}, 1'b0);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {20'd16, 2'b00, DIR_DOWN},  1'b0);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {20'd16, 2'b00, DIR_LEFT},  1'b0);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {20'd16, 2'b00, DIR_UP},    1'b1);
    // Bad direction codes at both ends of their range: the length is dropped.
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {LEN_MAX, NIB_BAD_MAX}, 1'b0);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {20'd0, NIB_BAD_MIN},   1'b0);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {LEN_MAX, 2'b00, DIR_DOWN}, 1'b0);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), {LEN_MAX, 2'b00, DIR_UP},   1'b1);
    // The all-ones and all-zeros hex words as paths of their own.
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), '1, 1'b1);
    send_step(2'($urandom), FIELD_LEN_BITS'($urandom), '0, 1'b1);
    wait_idle();

    // Random paths with idling on both sides, switching modes between phases.
    idle_on  = 1'b1;
    stall_on = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph % 2 == 1);
      random_phase(130);
      wait_idle();
    end

    // Back pressure: the output holds off while single-step paths keep
    // coming, each of which carries a result, so the pipeline fills.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (PRESSURE_PATHS) begin
      mv.d   = dir_e'($urandom_range(0, 3));
      mv.len = pick_len();
      mv.bad = 1'b0;
      send_move(mv, 1'b1);
    end
    wait_idle();

    // One long open path of full-length steps that builds large coordinates,
    // a large perimeter and a large shoelace sum.
    stall_on = 1'b0;
    write_mode(1'b0);
    repeat (WALK_DOWN) send_step(DIR_DOWN, LEN_MAX, HEX_BITS'($urandom), 1'b0);
    for (int i = 0; i < WALK_RIGHT; i++)
      send_step(DIR_RIGHT, LEN_MAX, HEX_BITS'($urandom), i == WALK_RIGHT - 1);
    wait_idle();

    // Final stretch at full rate with no idling on either side.
    write_mode(1'b1);
    random_phase(150);
    wait_idle();

    sb.check_drained();
    $display("Walked %0d steps in both length modes and checked %0d cell counts.",
             sb.steps_seen, sb.results_seen);
    $display("Paths left open: %0d, with bad direction codes: %0d, with overflow: %0d.",
             sb.unclosed_seen, sb.bad_seen, sb.ovf_seen);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
